// ===== hdl/sprq_pkg.sv =====
// Shared types, codes and constants for the sorted priority queue.
`timescale 1ns / 1ps

package sprq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int PRI_W        = 16;
   localparam int STATUS_W     = 2;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic                     occ;
      logic signed [VALUE_W-1:0] data;
      logic signed [PRI_W-1:0]   pri;
   } sprq_entry_type;

   typedef struct packed {
      logic                     push;
      logic                     pop;
      logic signed [VALUE_W-1:0] data;
      logic signed [PRI_W-1:0]   pri;
   } sprq_cmd_type;

endpackage

// ===== hdl/sprq_cell.sv =====
// One slot of the sorted cell row: holds an entry, shifts toward head or tail.
`timescale 1ns / 1ps

module sprq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  sprq_pkg::sprq_cmd_type   cmd,
   input  sprq_pkg::sprq_entry_type left_entry,
   input  logic                    left_keep,
   input  sprq_pkg::sprq_entry_type right_entry,
   output sprq_pkg::sprq_entry_type entry,
   output logic                    keep,
   output logic                    occ_next
);
   import sprq_pkg::*;

   logic                      occ_ff;
   logic signed [VALUE_W-1:0] data_ff;
   logic signed [PRI_W-1:0]   pri_ff;
   sprq_entry_type            entry_in;

   assign entry.occ  = occ_ff;
   assign entry.data = data_ff;
   assign entry.pri  = pri_ff;

   // stays put on insert when it ranks at or above the new item
   assign keep = occ_ff && (pri_ff >= cmd.pri);

   always_comb begin
      entry_in = entry;
      if (cmd.push) begin
         if (!keep) begin
            if (left_keep) begin
               entry_in.occ  = 1'b1;
               entry_in.data = cmd.data;
               entry_in.pri  = cmd.pri;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end
   end

   assign occ_next = entry_in.occ;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= entry_in.occ;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= entry_in.data;
      pri_ff  <= entry_in.pri;
   end

endmodule

// ===== hdl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: cell row plus result register.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_stall   req_opcode, req_item_value, req_item_priority
//   rsp      out  rsp_valid / rsp_stall   rsp_status, rsp_head_value, rsp_head_priority,
//                                         rsp_now_empty, rsp_now_full
//
// One item per cycle while the input is not stalled: every cell of the row updates in the cycle the item is accepted.
// The result is captured in the output register when the item is accepted.
// Reset clears all occupancy flags; no item is taken while reset is high.
// The input stalls only during reset or while a held result is itself stalled.
`timescale 1ns / 1ps

module sorted_priority_queue_unit #(
   parameter int CAPACITY = sprq_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic signed [sprq_pkg::VALUE_W-1:0]   req_item_value,
   input  logic signed [sprq_pkg::PRI_W-1:0]     req_item_priority,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sprq_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [sprq_pkg::VALUE_W-1:0]   rsp_head_value,
   output logic signed [sprq_pkg::PRI_W-1:0]     rsp_head_priority,
   output logic                                  rsp_now_empty,
   output logic                                  rsp_now_full
);
   import sprq_pkg::*;

   sprq_cmd_type          cmd;
   sprq_entry_type        entries [CAPACITY];
   sprq_entry_type        left_e  [CAPACITY];
   sprq_entry_type        right_e [CAPACITY];
   logic [CAPACITY-1:0]   keeps;
   logic [CAPACITY-1:0]   left_keeps;
   logic [CAPACITY-1:0]   occ_vec;
   logic [CAPACITY-1:0]   occ_next;
   logic                  accept;
   logic                  is_full;
   logic                  is_empty;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic signed [VALUE_W-1:0] head_value_ff, head_value_in;
   logic signed [PRI_W-1:0]   head_pri_ff, head_pri_in;
   logic                      now_empty_ff, now_full_ff;

   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   assign is_full  = entries[CAPACITY-1].occ;
   assign is_empty = ~entries[0].occ;

   assign cmd.push = accept && (req_opcode == OP_ENQUEUE) && !is_full;
   assign cmd.pop  = accept && (req_opcode == OP_DEQUEUE) && !is_empty;
   assign cmd.data = req_item_value;
   assign cmd.pri  = req_item_priority;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_e[i]     = '0;
         assign left_keeps[i] = 1'b1;
      end else begin : g_mid
         assign left_e[i]     = entries[i-1];
         assign left_keeps[i] = keeps[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_e[i] = '0;
      end else begin : g_body
         assign right_e[i] = entries[i+1];
      end
      assign occ_vec[i] = entries[i].occ;

      sprq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_e[i]),
         .left_keep   (left_keeps[i]),
         .right_entry (right_e[i]),
         .entry       (entries[i]),
         .keep        (keeps[i]),
         .occ_next    (occ_next[i])
      );
   end

   always_comb begin
      status_in     = ST_DONE;
      head_value_in = '0;
      head_pri_in   = '0;
      if (req_opcode == OP_ENQUEUE) begin
         if (is_full) status_in = ST_FULL;
      end else begin
         if (is_empty) begin
            status_in = ST_EMPTY;
         end else begin
            head_value_in = entries[0].data;
            head_pri_in   = entries[0].pri;
         end
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         head_value_ff <= head_value_in;
         head_pri_ff   <= head_pri_in;
         now_empty_ff  <= ~occ_next[0];
         now_full_ff   <= occ_next[CAPACITY-1];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_value    = head_value_ff;
   assign rsp_head_priority = head_pri_ff;
   assign rsp_now_empty     = now_empty_ff;
   assign rsp_now_full      = now_full_ff;

   // occupied cells always form a contiguous run from the head
   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      (occ_vec & (occ_vec + 1'b1)) == '0)
      else $error("occupancy has a gap");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> $countones(occ_vec) == $past($countones(occ_vec)) + 1)
      else $error("insert did not add one entry");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> $countones(occ_vec) == $past($countones(occ_vec)) - 1)
      else $error("removal did not drop one entry");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_FULL) |-> now_full_ff && !now_empty_ff)
      else $error("rejected insert without full flag");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_EMPTY) |-> now_empty_ff && (head_value_ff == '0))
      else $error("rejected removal with data or without empty flag");

endmodule

// ===== bench/tb_sorted_priority_queue_unit.sv =====
// Self-checking testbench for sorted_priority_queue_unit: directed table, random traffic, model.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;
   import sprq_pkg::*;

   localparam int QCAP          = CAPACITY_DEF;
   localparam int TOTAL_ITEMS   = 1350;
   localparam int QUIET_ITEMS   = 250;
   localparam int PRESSURE_AT   = 400;
   localparam int PRESSURE_LEN  = 80;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] head_value;
      logic signed [PRI_W-1:0]   head_priority;
      logic                      now_empty;
      logic                      now_full;
   } qresult_type;

   typedef struct packed {
      logic                      op;
      logic signed [VALUE_W-1:0] val;
      logic signed [PRI_W-1:0]   pri;
      logic                      typed;
      qresult_type               exp;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_opcode = OP_ENQUEUE;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic signed [PRI_W-1:0]   req_item_priority = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_head_value;
   logic signed [PRI_W-1:0]   rsp_head_priority;
   logic                      rsp_now_empty;
   logic                      rsp_now_full;

   logic                      drv_typed = 1'b0;
   qresult_type               drv_exp = '0;

   logic signed [VALUE_W-1:0] shadow_values [QCAP];
   logic signed [PRI_W-1:0]   shadow_pris [QCAP];
   int                        shadow_count = 0;

   qresult_type               pending_results [$];
   stim_row_type              directed_rows [$];
   qresult_type               want;
   qresult_type               got;
   int                        req_taken = 0;
   int                        items_sent = 0;
   int                        err_count = 0;

   sorted_priority_queue_unit #(.CAPACITY(QCAP)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_head_value    (rsp_head_value),
      .rsp_head_priority (rsp_head_priority),
      .rsp_now_empty     (rsp_now_empty),
      .rsp_now_full      (rsp_now_full)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sorted-array shadow: insert behind equal or higher priority, pop the head
   function automatic qresult_type queue_step(logic op, logic signed [VALUE_W-1:0] val,
                                              logic signed [PRI_W-1:0] pri);
      qresult_type r;
      int          pos;
      r = '0;
      r.status = ST_DONE;
      if (op == OP_ENQUEUE) begin
         if (shadow_count >= QCAP) begin
            r.status = ST_FULL;
         end else begin
            pos = shadow_count;
            while (pos > 0 && shadow_pris[pos-1] < pri) begin
               shadow_values[pos] = shadow_values[pos-1];
               shadow_pris[pos]   = shadow_pris[pos-1];
               pos--;
            end
            shadow_values[pos] = val;
            shadow_pris[pos]   = pri;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.head_value    = shadow_values[0];
         r.head_priority = shadow_pris[0];
         for (int i = 1; i < shadow_count; i++) begin
            shadow_values[i-1] = shadow_values[i];
            shadow_pris[i-1]   = shadow_pris[i];
         end
         shadow_count--;
      end
      r.now_empty = (shadow_count == 0);
      r.now_full  = (shadow_count == QCAP);
      return r;
   endfunction

   function automatic void add_row(logic op, logic signed [VALUE_W-1:0] val,
                                   logic signed [PRI_W-1:0] pri, logic typed,
                                   logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] hv,
                                   logic signed [PRI_W-1:0] hp, logic em, logic fu);
      stim_row_type row;
      row.op  = op;
      row.val = val;
      row.pri = pri;
      row.typed = typed;
      row.exp.status = st;
      row.exp.head_value = hv;
      row.exp.head_priority = hp;
      row.exp.now_empty = em;
      row.exp.now_full = fu;
      directed_rows.push_back(row);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: status %0d value %h", rsp_status, rsp_head_value);
               err_count++;
            end else begin
               want = pending_results.pop_front();
               got.status        = rsp_status;
               got.head_value    = rsp_head_value;
               got.head_priority = rsp_head_priority;
               got.now_empty     = rsp_now_empty;
               got.now_full      = rsp_now_full;
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  err_count++;
               end
               if (got.head_value !== want.head_value) begin
                  $error("head_value: expected %h, got %h", want.head_value, got.head_value);
                  err_count++;
               end
               if (got.head_priority !== want.head_priority) begin
                  $error("head_priority: expected %h, got %h",
                         want.head_priority, got.head_priority);
                  err_count++;
               end
               if (got.now_empty !== want.now_empty) begin
                  $error("now_empty: expected %0d, got %0d", want.now_empty, got.now_empty);
                  err_count++;
               end
               if (got.now_full !== want.now_full) begin
                  $error("now_full: expected %0d, got %0d", want.now_full, got.now_full);
                  err_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = queue_step(req_opcode, req_item_value, req_item_priority);
            if (drv_typed) begin
               pending_results.push_back(drv_exp);
            end else begin
               pending_results.push_back(want);
            end
            req_taken++;
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("sorted_priority_queue_unit test failed");
      $finish;
   end

   // result side: random stall bursts, one long hold-off, none in the tail
   initial begin : receiver
      logic level;
      int   n;
      bit   held_off;
      held_off = 1'b0;
      @(negedge clock);
      forever begin
         if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS) begin
            level = 1'b0;
            n = 1;
         end else if (!held_off && items_sent >= PRESSURE_AT) begin
            level = 1'b1;
            n = PRESSURE_LEN;
            held_off = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            level = 1'b1;
            n = $urandom_range(1, 18);
         end else begin
            level = 1'b0;
            n = $urandom_range(1, 30);
         end
         rsp_stall <= level;
         repeat (n) @(negedge clock);
      end
   end

   task automatic pace_sender();
      bit busy_window;
      busy_window = (items_sent >= PRESSURE_AT && items_sent < PRESSURE_AT + 60);
      if (items_sent < TOTAL_ITEMS - QUIET_ITEMS && !busy_window
          && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   task automatic send_item(logic op, logic signed [VALUE_W-1:0] val,
                            logic signed [PRI_W-1:0] pri, logic typed, qresult_type exp);
      int seen;
      seen = req_taken;
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_item_value    <= val;
      req_item_priority <= pri;
      drv_typed         <= typed;
      drv_exp           <= exp;
      do @(negedge clock); while (req_taken == seen);
      items_sent++;
   endtask

   initial begin : stimulus
      stim_row_type          row;
      logic                  op;
      logic signed [VALUE_W-1:0] val;
      logic signed [PRI_W-1:0]   pri;
      int                    chunk;
      int                    enq_pct;
      int                    sel;

      add_row(OP_DEQUEUE, 32'sd0, 16'sd0, 1'b1, ST_EMPTY, '0, '0, 1'b1, 1'b0);
      add_row(OP_ENQUEUE, 32'sh7FFFFFFF, 16'sh7FFF, 1'b1, ST_DONE, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'sh80000000, 16'sh8000, 1'b1, ST_DONE, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'sd1, 16'sd3, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, -32'sd2, 16'sd3, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'sd3, -16'sd1, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, -32'sd4, 16'sd3, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'sd5, 16'sd100, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, -32'sd6, -16'sd1, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'sd7, 16'sd0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'h5555AAAA, 16'sd100, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'hAAAA5555, 16'sd3, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'sd10, -16'sd5, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'sd11, 16'sd0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'sd12, -16'sd1, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'sd13, 16'sh8000, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(OP_ENQUEUE, 32'h0000ABCD, 16'sd0, 1'b1, ST_DONE, '0, '0, 1'b0, 1'b1);
      add_row(OP_ENQUEUE, 32'sd99, 16'sh7FFF, 1'b1, ST_FULL, '0, '0, 1'b0, 1'b1);
      add_row(OP_DEQUEUE, 32'sd0, 16'sd0, 1'b1, ST_DONE, 32'sh7FFFFFFF, 16'sh7FFF,
              1'b0, 1'b0);
      add_row(OP_DEQUEUE, 32'sd0, 16'sd0, 1'b0, '0, '0, '0, 1'b0, 1'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         pace_sender();
         send_item(row.op, row.val, row.pri, row.typed, row.exp);
      end

      // fill-heavy, balanced and drain-heavy stretches so full and empty both recur
      while (items_sent < TOTAL_ITEMS) begin
         chunk = $urandom_range(10, 50);
         case ($urandom_range(0, 2))
            0: begin
               enq_pct = 90;
            end
            1: begin
               enq_pct = 50;
            end
            default: begin
               enq_pct = 10;
            end
         endcase
         repeat (chunk) begin
            if (items_sent < TOTAL_ITEMS) begin
               op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
               val = $urandom;
               sel = $urandom_range(0, 9);
               if (sel < 4) begin
                  pri = PRI_W'($urandom_range(0, 4));
                  pri = pri - 16'sd2;
               end else if (sel < 7) begin
                  pri = PRI_W'($urandom);
               end else if (sel == 7) begin
                  pri = 16'sh7FFF;
               end else if (sel == 8) begin
                  pri = 16'sh8000;
               end else begin
                  pri = PRI_W'($urandom_range(0, 200));
               end
               pace_sender();
               send_item(op, val, pri, 1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (err_count == 0) begin
         $display("sorted_priority_queue_unit test passed");
      end else begin
         $display("sorted_priority_queue_unit test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/sprq_pkg.sv
hdl/sprq_cell.sv
hdl/sorted_priority_queue_unit.sv
bench/tb_sorted_priority_queue_unit.sv
